### hdl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the one-wire bus master: transaction
// payloads, configuration set, request and drive codes, sequencer phases.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

    // configuration registers
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW_TIME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOVERY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW_TIME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LOW_TIME     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LENGTH       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE_DELAY = 3'd6;

    localparam logic [CFG_W-1:0] RST_RESET_LOW_TIME    = 10'd480;
    localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT     = 10'd70;
    localparam logic [CFG_W-1:0] RST_RESET_RECOVERY    = 10'd410;
    localparam logic [CFG_W-1:0] RST_SHORT_LOW_TIME    = 10'd6;
    localparam logic [CFG_W-1:0] RST_LONG_LOW_TIME     = 10'd60;
    localparam logic [CFG_W-1:0] RST_SLOT_LENGTH       = 10'd70;
    localparam logic [CFG_W-1:0] RST_READ_SAMPLE_DELAY = 10'd9;

    // request codes
    localparam logic [2:0] REQ_NONE       = 3'd0;
    localparam logic [2:0] REQ_RESET      = 3'd1;
    localparam logic [2:0] REQ_WRITE_BYTE = 3'd2;
    localparam logic [2:0] REQ_READ_BYTE  = 3'd3;
    localparam logic [2:0] REQ_WRITE_BIT  = 3'd4;
    localparam logic [2:0] REQ_READ_BIT   = 3'd5;

    // line drive codes
    localparam logic [1:0] DRV_LOW  = 2'd0;
    localparam logic [1:0] DRV_HIGH = 2'd1;
    localparam logic [1:0] DRV_REL  = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] BITS_SINGLE   = 4'd1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_REC,
        PH_BIT_LOW,
        PH_BIT_REL
    } phase_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_data;
        logic       line_level;
    } owbm_in_t;

    typedef struct packed {
        logic [1:0] line_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_data;
        logic       presence;
    } owbm_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] presence_wait;
        logic [CFG_W-1:0] reset_recovery;
        logic [CFG_W-1:0] short_low_time;
        logic [CFG_W-1:0] long_low_time;
        logic [CFG_W-1:0] slot_length;
        logic [CFG_W-1:0] read_sample_delay;
    } owbm_cfg_t;

endpackage

`default_nettype wire

### hdl/owbm_cfg.sv
// ----------------------------------------------------------------------------
// owbm_cfg
// Timing register file of the one-wire bus master, written through a plain
// write port; writes to an index past the last register are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_cfg
    import owbm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output owbm_cfg_t                 cfg
);

    owbm_cfg_t cfg_reg;
    owbm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RESET_LOW_TIME:    cfg_next.reset_low_time    = cfg_data;
                CFG_PRESENCE_WAIT:     cfg_next.presence_wait     = cfg_data;
                CFG_RESET_RECOVERY:    cfg_next.reset_recovery    = cfg_data;
                CFG_SHORT_LOW_TIME:    cfg_next.short_low_time    = cfg_data;
                CFG_LONG_LOW_TIME:     cfg_next.long_low_time     = cfg_data;
                CFG_SLOT_LENGTH:       cfg_next.slot_length       = cfg_data;
                CFG_READ_SAMPLE_DELAY: cfg_next.read_sample_delay = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time    <= RST_RESET_LOW_TIME;
            cfg_reg.presence_wait     <= RST_PRESENCE_WAIT;
            cfg_reg.reset_recovery    <= RST_RESET_RECOVERY;
            cfg_reg.short_low_time    <= RST_SHORT_LOW_TIME;
            cfg_reg.long_low_time     <= RST_LONG_LOW_TIME;
            cfg_reg.slot_length       <= RST_SLOT_LENGTH;
            cfg_reg.read_sample_delay <= RST_READ_SAMPLE_DELAY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hdl/owbm_step.sv
// ----------------------------------------------------------------------------
// owbm_step
// Bus sequencer: holds the command state and advances it by one tick per
// accepted transaction, producing that tick's result combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_step
    import owbm_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step_en,
    input  wire owbm_in_t  tick_in,
    input  wire owbm_cfg_t cfg,
    output owbm_out_t      result
);

    localparam int CMP_W = (TIMER_BITS > CFG_W + 1) ? TIMER_BITS : CFG_W + 1;

    phase_t                phase_reg,  phase_next;
    logic [TIMER_BITS-1:0] tick_reg,   tick_next;
    logic [3:0]            bit_idx_reg, bit_idx_next;
    logic [7:0]            shift_reg,  shift_next;
    logic                  pres_reg,   pres_next;
    logic [1:0]            drive_reg,  drive_next;
    logic [2:0]            op_reg,     op_next;

    logic [TIMER_BITS-1:0] tick_inc;
    logic [CFG_W-1:0]      low_time;
    logic [CFG_W:0]        rel_len;
    logic [CFG_W:0]        sample_end;
    logic [3:0]            nbits;
    logic                  is_rd;
    logic                  is_wr;
    logic                  start;

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        pres_next    = pres_reg;
        drive_next   = drive_reg;
        op_next      = op_reg;
        result       = '0;

        // command start, only from idle
        start = (phase_reg == PH_IDLE) && (tick_in.req_type >= REQ_RESET)
                && (tick_in.req_type <= REQ_READ_BIT);
        if (start)
        begin
            op_next      = tick_in.req_type;
            tick_next    = '0;
            bit_idx_next = '0;
            if (tick_in.req_type == REQ_RESET)
            begin
                pres_next  = 1'b0;
                phase_next = PH_RST_LOW;
            end
            else
            begin
                if (tick_in.req_type == REQ_WRITE_BYTE)
                    shift_next = tick_in.tx_data;
                else if (tick_in.req_type == REQ_WRITE_BIT)
                    shift_next = {7'b0, tick_in.tx_data[0]};
                else
                    shift_next = 8'h00;
                phase_next = PH_BIT_LOW;
            end
        end

        result.busy_res = (phase_next != PH_IDLE);

        is_rd = (op_next == REQ_READ_BYTE) || (op_next == REQ_READ_BIT);
        is_wr = (op_next == REQ_WRITE_BYTE) || (op_next == REQ_WRITE_BIT);
        nbits = ((op_next == REQ_WRITE_BYTE) || (op_next == REQ_READ_BYTE))
                ? BITS_PER_BYTE : BITS_SINGLE;

        // slot timing of the current bit
        low_time   = (is_wr && !shift_next[0]) ? cfg.long_low_time : cfg.short_low_time;
        sample_end = (CFG_W+1)'(cfg.read_sample_delay) + 1'b1;
        if (cfg.slot_length > low_time)
            rel_len = (CFG_W+1)'(cfg.slot_length - low_time);
        else
            rel_len = (CFG_W+1)'(1);
        if (is_rd && (rel_len < sample_end))
            rel_len = sample_end;

        tick_inc = tick_next + 1'b1;

        unique case (phase_next)
            PH_IDLE:
            begin
            end
            PH_RST_LOW:
            begin
                drive_next = DRV_LOW;
                tick_next  = tick_inc;
                if (CMP_W'(tick_inc) >= CMP_W'(cfg.reset_low_time))
                begin
                    phase_next = PH_RST_WAIT;
                    tick_next  = '0;
                end
            end
            PH_RST_WAIT:
            begin
                drive_next = DRV_REL;
                tick_next  = tick_inc;
                if (CMP_W'(tick_inc) >= CMP_W'(cfg.presence_wait))
                begin
                    phase_next = PH_RST_REC;
                    tick_next  = '0;
                end
            end
            PH_RST_REC:
            begin
                drive_next = DRV_REL;
                // first recovery tick samples presence
                if (tick_next == '0)
                    pres_next = ~tick_in.line_level;
                tick_next = tick_inc;
                if (CMP_W'(tick_inc) >= CMP_W'(cfg.reset_recovery))
                begin
                    phase_next      = PH_IDLE;
                    tick_next       = '0;
                    result.done_res = 1'b1;
                end
            end
            PH_BIT_LOW:
            begin
                drive_next = DRV_LOW;
                tick_next  = tick_inc;
                if (CMP_W'(tick_inc) >= CMP_W'(low_time))
                begin
                    phase_next = PH_BIT_REL;
                    tick_next  = '0;
                end
            end
            PH_BIT_REL:
            begin
                drive_next = DRV_REL;
                if (is_rd && (CMP_W'(tick_next) == CMP_W'(cfg.read_sample_delay)))
                begin
                    if (op_next == REQ_READ_BYTE)
                        shift_next = {tick_in.line_level, shift_next[7:1]};
                    else
                        shift_next = {7'b0, tick_in.line_level};
                end
                tick_next = tick_inc;
                if (CMP_W'(tick_inc) >= CMP_W'(rel_len))
                begin
                    if (is_wr)
                        shift_next = shift_next >> 1;
                    bit_idx_next = bit_idx_next + 1'b1;
                    tick_next    = '0;
                    if (bit_idx_next >= nbits)
                    begin
                        phase_next      = PH_IDLE;
                        result.done_res = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BIT_LOW;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                drive_next = DRV_REL;
            end
        endcase

        result.line_drive = drive_next;
        result.presence   = pres_next;
        result.rx_data    = ((phase_next == PH_IDLE) && is_rd) ? shift_next : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            pres_reg    <= 1'b0;
            drive_reg   <= DRV_REL;
            op_reg      <= REQ_NONE;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            pres_reg    <= pres_next;
            drive_reg   <= drive_next;
            op_reg      <= op_next;
        end
    end

endmodule

`default_nettype wire

### hdl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Single-wire bus master sequencer, advanced by one microsecond tick per
// input transaction, with one result transaction per tick.
// ----------------------------------------------------------------------------
// Every input transaction is one timing tick carrying an optional command
// (reset with presence detect, write or read of a byte, write or read of a
// bit) and the sampled line level. Commands are taken only while idle; one
// arriving while busy, or an unused request code, is ignored. Bytes go least
// significant bit first. Each tick yields exactly one result: the line drive
// (low or released, never driven high), busy, a one-tick done flag, the read
// data (valid while idle after a read, zero otherwise) and the presence flag
// of the last bus reset. A tick is taken in every clock cycle without
// back-pressure: the whole sequencer step is one pass of combinational
// logic from the state registers into the output register. in_ready drops
// only while the output register holds a result out_ready has not taken.
// The user is to write the timing registers through the cfg port while no
// command is running, not enforced by the block; writes take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master
    import owbm_pkg::*;
#(
    parameter int TIMER_BITS = 10   // width of the tick counter, 9 to 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // tick transactions in
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire owbm_in_t             in_data,
    // result transactions out
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      owbm_out_t            out_data,
    // timing register write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    owbm_cfg_t cfg;
    owbm_out_t step_result;
    logic      in_accept;

    logic      out_valid_reg, out_valid_next;
    owbm_out_t out_data_reg;

    owbm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer state moves only when a tick is accepted
    owbm_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (in_accept),
        .tick_in (in_data),
        .cfg     (cfg),
        .result  (step_result)
    );

    // output register frees up in the same cycle it is read
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        if (in_accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### hdl/owbm_checker.sv
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks of the one-wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_checker
    import owbm_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire owbm_out_t out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // every accepted tick shows up as a result in the following cycle
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted tick gave no result");

    // done only ends a running command
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> out_data.busy_res)
        else $error("done without busy");

    // the line is never driven high
    a_drive_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.line_drive == DRV_LOW) || (out_data.line_drive == DRV_REL))
        else $error("illegal line drive");

    // no read data in the middle of a command
    a_rx_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.busy_res && !out_data.done_res |-> out_data.rx_data == 8'h00)
        else $error("read data while busy");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

### tb/tb_one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// Self-checking bench for the one-wire bus master: every tick transaction is
// run through a cycle-true model of the slot sequencer and every result
// transaction is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;
    import owbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_TICKS    = 60;
    localparam int NUM_TIMERS     = 7;
    localparam int TICK_W         = 10;
    localparam int LVL_RANDOM     = 2;

    // request codes the block must treat as no command
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    typedef logic [CFG_W-1:0] timer_set_t [NUM_TIMERS];

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // one directed command; rx and presence are pinned only where obvious
    typedef struct {
        logic [2:0] req;
        logic [7:0] tx;
        logic       lvl;
        bit         pinned;
        logic [7:0] rx;
        logic       pres;
    } dir_row_t;

    // pinned values for one result, by its position in the result stream
    typedef struct {
        int         idx;
        logic [7:0] rx;
        logic       pres;
    } pin_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    owbm_in_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    owbm_out_t   out_data;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    one_wire_bus_master u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // sequencer model: state, timing registers and counters
    // ------------------------------------------------------------------------
    phase_t            bus_phase = PH_IDLE;
    logic [TICK_W-1:0] slot_tick = '0;
    logic [3:0]        bit_cnt   = '0;
    logic [7:0]        data_sr   = '0;
    logic              pres_flag = 1'b0;
    logic [1:0]        drv_mode  = DRV_REL;
    logic [2:0]        bus_op    = REQ_NONE;
    timer_set_t        timers = '{RST_RESET_LOW_TIME, RST_PRESENCE_WAIT,
                                  RST_RESET_RECOVERY, RST_SHORT_LOW_TIME,
                                  RST_LONG_LOW_TIME, RST_SLOT_LENGTH,
                                  RST_READ_SAMPLE_DELAY};

    owbm_out_t bus_expect [$];      // predicted results, oldest first
    pin_t      pinned_vals [$];
    int        n_ticks = 0;
    int        n_seen = 0;
    int        n_errors = 0;
    int        n_settings = 1;      // reset values count as one setting
    int        n_started [6];
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        quiet_cycles = 0;

    // advance the bus sequencer by one tick and return the tick's result
    task automatic step_bus(input owbm_in_t t, output owbm_out_t r);
        logic [CFG_W-1:0] low_len;
        logic [CFG_W:0]   rel_len;
        logic [CFG_W:0]   smp_end;
        logic [3:0]       nbits;
        logic             rd;
        logic             wr;
        logic             done;
        r = '0;
        done = 1'b0;
        // a command is taken only while idle; codes 6 and 7 never start one
        if (bus_phase == PH_IDLE && t.req_type >= REQ_RESET && t.req_type <= REQ_READ_BIT)
        begin
            n_started[t.req_type]++;
            bus_op = t.req_type;
            slot_tick = '0;
            bit_cnt = '0;
            if (t.req_type == REQ_RESET)
            begin
                pres_flag = 1'b0;
                bus_phase = PH_RST_LOW;
            end
            else
            begin
                case (t.req_type)
                    REQ_WRITE_BYTE: data_sr = t.tx_data;
                    REQ_WRITE_BIT:  data_sr = {7'b0, t.tx_data[0]};
                    default:        data_sr = '0;
                endcase
                bus_phase = PH_BIT_LOW;
            end
        end
        r.busy_res = (bus_phase != PH_IDLE);
        rd = (bus_op == REQ_READ_BYTE) || (bus_op == REQ_READ_BIT);
        wr = (bus_op == REQ_WRITE_BYTE) || (bus_op == REQ_WRITE_BIT);
        // a zero bit keeps the line low for the long time, all else short
        low_len = (wr && !data_sr[0]) ? timers[CFG_LONG_LOW_TIME]
                                      : timers[CFG_SHORT_LOW_TIME];
        case (bus_phase)
            PH_RST_LOW:
            begin
                drv_mode = DRV_LOW;
                slot_tick = slot_tick + 1'b1;
                if (slot_tick >= timers[CFG_RESET_LOW_TIME])
                begin
                    bus_phase = PH_RST_WAIT;
                    slot_tick = '0;
                end
            end
            PH_RST_WAIT:
            begin
                drv_mode = DRV_REL;
                slot_tick = slot_tick + 1'b1;
                if (slot_tick >= timers[CFG_PRESENCE_WAIT])
                begin
                    bus_phase = PH_RST_REC;
                    slot_tick = '0;
                end
            end
            PH_RST_REC:
            begin
                drv_mode = DRV_REL;
                // presence is sampled on the first recovery tick
                if (slot_tick == '0)
                    pres_flag = ~t.line_level;
                slot_tick = slot_tick + 1'b1;
                if (slot_tick >= timers[CFG_RESET_RECOVERY])
                begin
                    bus_phase = PH_IDLE;
                    slot_tick = '0;
                    done = 1'b1;
                end
            end
            PH_BIT_LOW:
            begin
                drv_mode = DRV_LOW;
                slot_tick = slot_tick + 1'b1;
                if (slot_tick >= low_len)
                begin
                    bus_phase = PH_BIT_REL;
                    slot_tick = '0;
                end
            end
            PH_BIT_REL:
            begin
                // released part lasts at least one tick, for reads past the sample
                rel_len = (timers[CFG_SLOT_LENGTH] > low_len) ?
                          (CFG_W+1)'(timers[CFG_SLOT_LENGTH] - low_len) : (CFG_W+1)'(1);
                smp_end = (CFG_W+1)'(timers[CFG_READ_SAMPLE_DELAY]) + 11'd1;
                if (rd && rel_len < smp_end)
                    rel_len = smp_end;
                nbits = (bus_op == REQ_WRITE_BYTE || bus_op == REQ_READ_BYTE) ?
                        BITS_PER_BYTE : BITS_SINGLE;
                drv_mode = DRV_REL;
                if (rd && slot_tick == timers[CFG_READ_SAMPLE_DELAY])
                    data_sr = (bus_op == REQ_READ_BYTE) ? {t.line_level, data_sr[7:1]}
                                                        : {7'b0, t.line_level};
                slot_tick = slot_tick + 1'b1;
                if ((CFG_W+1)'(slot_tick) >= rel_len)
                begin
                    if (wr)
                        data_sr = data_sr >> 1;
                    bit_cnt = bit_cnt + 1'b1;
                    slot_tick = '0;
                    if (bit_cnt >= nbits)
                    begin
                        bus_phase = PH_IDLE;
                        done = 1'b1;
                    end
                    else
                        bus_phase = PH_BIT_LOW;
                end
            end
            default:
            begin
                bus_phase = PH_IDLE;
                drv_mode = DRV_REL;
            end
        endcase
        // read data shows only while idle after a read
        if (bus_phase == PH_IDLE && rd)
            r.rx_data = data_sr;
        r.line_drive = drv_mode;
        r.done_res = done;
        r.presence = pres_flag;
    endtask

    // ------------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------------

    // offer one tick transaction, predict its result once it is accepted
    task automatic send_tick(input logic [2:0] req, input logic [7:0] tx, input logic lvl);
        owbm_in_t  t;
        owbm_out_t r;
        t.req_type = req;
        t.tx_data = tx;
        t.line_level = lvl;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        step_bus(t, r);
        bus_expect.push_back(r);
        n_ticks++;
    endtask

    // issue a command and keep ticking until the sequencer is idle again;
    // ticks sent while busy carry random request codes, which must be ignored
    task automatic run_command(input logic [2:0] req, input logic [7:0] tx, input int lvl);
        send_tick(req, tx, (lvl == LVL_RANDOM) ? 1'($urandom_range(1)) : lvl[0]);
        while (bus_phase != PH_IDLE)
            send_tick(3'($urandom_range(7)), 8'($urandom_range(255)),
                      (lvl == LVL_RANDOM) ? 1'($urandom_range(1)) : lvl[0]);
    endtask

    // stop offering ticks and wait for every predicted result to come out
    task automatic drain_results;
        in_valid <= 1'b0;
        while (bus_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all timing registers back to back; only called while idle
    task automatic set_timers(input timer_set_t v);
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= v[i];
            @(posedge clk);
            timers[i] = v[i];
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin idle_pct = 58; stall_pct = 0;  end
            IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 58; end
            default:       begin idle_pct = 34; stall_pct = 34; end
        endcase
    endtask

    // directed commands at a compact timing, line held at one level per command
    dir_row_t dir_rows [13] = '{
        '{REQ_NONE,       8'h00, 1'b1, 1'b1, 8'h00, 1'b0},  // no read or bus reset yet
        '{REQ_RESET,      8'h00, 1'b0, 1'b1, 8'h00, 1'b1},  // line low at sample: presence
        '{REQ_WRITE_BYTE, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b1},  // presence kept, rx zero
        '{REQ_WRITE_BYTE, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_WRITE_BYTE, 8'hA5, 1'b0, 1'b0, 8'h00, 1'b0},
        '{REQ_READ_BYTE,  8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
        '{REQ_READ_BYTE,  8'hFF, 1'b0, 1'b1, 8'h00, 1'b1},
        '{REQ_WRITE_BIT,  8'hFE, 1'b1, 1'b0, 8'h00, 1'b0},  // only bit 0 goes out
        '{REQ_WRITE_BIT,  8'h01, 1'b0, 1'b1, 8'h00, 1'b1},
        '{REQ_READ_BIT,   8'h00, 1'b1, 1'b1, 8'h01, 1'b1},
        '{REQ_UNUSED_6,   8'hFF, 1'b0, 1'b1, 8'h01, 1'b1},  // ignored, read data held
        '{REQ_UNUSED_7,   8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_RESET,      8'hFF, 1'b1, 1'b1, 8'h00, 1'b0}   // no device: presence clear
    };

    initial
    begin
        timer_set_t ts;
        int         start;
        int         k;
        logic [2:0] req;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one zero bit with the timing right after reset
        set_idling(IDLE_NONE);
        run_command(REQ_WRITE_BIT, 8'h00, LVL_RANDOM);
        drain_results;

        // directed commands over a compact timing, no idling
        ts[CFG_RESET_LOW_TIME]    = 10'd3;
        ts[CFG_PRESENCE_WAIT]     = 10'd2;
        ts[CFG_RESET_RECOVERY]    = 10'd3;
        ts[CFG_SHORT_LOW_TIME]    = 10'd1;
        ts[CFG_LONG_LOW_TIME]     = 10'd2;
        ts[CFG_SLOT_LENGTH]       = 10'd3;
        ts[CFG_READ_SAMPLE_DELAY] = 10'd1;
        set_timers(ts);
        foreach (dir_rows[i])
        begin
            run_command(dir_rows[i].req, dir_rows[i].tx, dir_rows[i].lvl);
            if (dir_rows[i].pinned)
                pinned_vals.push_back(pin_t'{n_ticks - 1, dir_rows[i].rx, dir_rows[i].pres});
        end
        drain_results;

        // random commands over short timings; first the all-minimum set,
        // then all registers zero (each acts as one tick), then random sets
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    foreach (ts[i])
                        ts[i] = 10'd1;
                    ts[CFG_SLOT_LENGTH] = 10'd2;
                end
                1:
                    foreach (ts[i])
                        ts[i] = '0;
                default:
                begin
                    ts[CFG_RESET_LOW_TIME]    = 10'($urandom_range(1, 20));
                    ts[CFG_PRESENCE_WAIT]     = 10'($urandom_range(1, 20));
                    ts[CFG_RESET_RECOVERY]    = 10'($urandom_range(1, 20));
                    ts[CFG_SHORT_LOW_TIME]    = 10'($urandom_range(1, 8));
                    ts[CFG_LONG_LOW_TIME]     = 10'($urandom_range(1, 20));
                    ts[CFG_SLOT_LENGTH]       = 10'($urandom_range(2, 24));
                    ts[CFG_READ_SAMPLE_DELAY] = 10'($urandom_range(1, 12));
                end
            endcase
            set_timers(ts);
            set_idling(idle_mode_t'(p % 4));
            start = n_ticks;
            while (n_ticks - start < PHASE_TICKS)
            begin
                if ($urandom_range(99) < 80)
                    run_command(3'($urandom_range(REQ_RESET, REQ_READ_BIT)),
                                8'($urandom_range(255)), LVL_RANDOM);
                else
                begin
                    // a lone tick with no command or an unused code
                    k = $urandom_range(2);
                    req = (k == 0) ? REQ_NONE : (k == 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
                    run_command(req, 8'($urandom_range(255)), LVL_RANDOM);
                end
            end
            drain_results;
        end

        // longest read slot: sample on release tick 1022, so the slot
        // counter runs up to its top value
        foreach (ts[i])
            ts[i] = 10'd1;
        ts[CFG_SLOT_LENGTH] = 10'd2;
        ts[CFG_READ_SAMPLE_DELAY] = 10'd1022;
        set_timers(ts);
        set_idling(IDLE_BOTH);
        run_command(REQ_READ_BIT, 8'h00, LVL_RANDOM);
        drain_results;

        if (bus_expect.size() != 0)
        begin
            $error("%0d results never arrived", bus_expect.size());
            n_errors++;
        end
        $display("covered %0d ticks over %0d timing settings and four idling mixes",
                 n_ticks, n_settings);
        $display("started %0d resets, %0d byte writes, %0d byte reads,",
                 n_started[REQ_RESET], n_started[REQ_WRITE_BYTE], n_started[REQ_READ_BYTE]);
        $display("        %0d bit writes, %0d bit reads",
                 n_started[REQ_WRITE_BIT], n_started[REQ_READ_BIT]);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // random back-pressure on the result channel
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endfunction

    owbm_out_t exp_res;

    // every result transaction is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (bus_expect.size() == 0)
            begin
                $error("result transaction with nothing expected");
                n_errors++;
            end
            else
            begin
                exp_res = bus_expect.pop_front();
                check_field("line_drive", 8'(exp_res.line_drive), 8'(out_data.line_drive));
                check_field("busy_res", 8'(exp_res.busy_res), 8'(out_data.busy_res));
                check_field("done_res", 8'(exp_res.done_res), 8'(out_data.done_res));
                check_field("rx_data", exp_res.rx_data, out_data.rx_data);
                check_field("presence", 8'(exp_res.presence), 8'(out_data.presence));
                if (pinned_vals.size() != 0 && pinned_vals[0].idx == n_seen)
                begin
                    check_field("rx_data", pinned_vals[0].rx, out_data.rx_data);
                    check_field("presence", 8'(pinned_vals[0].pres), 8'(out_data.presence));
                    void'(pinned_vals.pop_front());
                end
                n_seen++;
            end
        end
    end

    // watchdog: too long without any transaction ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
